### rtl/core/three_channel_programmable_timer_unit_macros.svh
// Assertion macros shared by the timer checker.
`ifndef THREE_CHANNEL_PROGRAMMABLE_TIMER_UNIT_MACROS_SVH
`define THREE_CHANNEL_PROGRAMMABLE_TIMER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define TCTMR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define TCTMR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live during reset
`define TCTMR_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tctmr_pkg.sv
// Package of types and constants for the three-channel timer.
package tctmr_pkg;

    localparam int NUM_CNT = 3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    localparam logic [2:0] ADDR_CTRL_A = 3'd0;  // control 0 or 2
    localparam logic [2:0] ADDR_CTRL_B = 3'd1;  // control 1 / status

    // control bit positions
    localparam int CTRL_HOLD     = 0;
    localparam int CTRL_INTCLK   = 1;
    localparam int CTRL_DUAL     = 2;
    localparam int CTRL_NORELOAD = 4;
    localparam int CTRL_IRQEN    = 6;

    localparam int STAT_IRQ = 7;

    localparam logic [15:0] COUNT_RESET = 16'hffff;

    typedef struct packed {
        logic [15:0] count;
        logic        fired;
    } t_cnt_step;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [2:0] expired;
    } t_result;

endpackage

### rtl/core/three_channel_programmable_timer_unit.sv
// Top level of the three-channel programmable timer.
//
// Request channel (i_in_valid / o_in_ready): one bus read, bus write or clock
// tick per request, selected by i_operation. Address and write data matter for
// reads and writes, the clock inputs for ticks only.
// Result channel (o_out_valid / i_out_ready): one result per request, in order,
// with read data, the composite interrupt and the per-counter expiry bits.
// The result is registered on the result side. Throughput: one request per
// cycle while the skid entry is empty; all register and counter updates happen
// in the accepting cycle, each counter step being one decrement and compare.
// An output register plus one skid entry sit on the result side, so a request
// is still taken while one result waits; o_in_ready drops only when both are
// full and rises again as soon as the receiver takes a result.
// Reset: all counters stopped, controls cleared, latches and counts 0xffff,
// flags and byte buffers cleared, result side empty.
module three_channel_programmable_timer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_address,
    input  logic [7:0] i_write_data,
    input  logic [2:0] i_external_clocks,
    input  logic       i_internal_clock,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic       o_irq,
    output logic [2:0] o_expired
);

    logic [7:0]  r_ctrl  [tctmr_pkg::NUM_CNT];
    logic [15:0] r_latch [tctmr_pkg::NUM_CNT];
    logic [15:0] r_count [tctmr_pkg::NUM_CNT];
    logic [2:0]  r_running;
    logic [2:0]  r_timeout;
    logic [2:0]  r_seen;
    logic [7:0]  r_hbuf;
    logic [7:0]  r_lbuf;

    logic [7:0]  n_ctrl  [tctmr_pkg::NUM_CNT];
    logic [15:0] n_latch [tctmr_pkg::NUM_CNT];
    logic [15:0] n_count [tctmr_pkg::NUM_CNT];
    logic [2:0]  n_running;
    logic [2:0]  n_timeout;
    logic [2:0]  n_seen;
    logic [7:0]  n_hbuf;
    logic [7:0]  n_lbuf;

    tctmr_pkg::t_cnt_step cnt_step [tctmr_pkg::NUM_CNT];
    tctmr_pkg::t_result   res;
    tctmr_pkg::t_result   r_out;
    tctmr_pkg::t_result   r_skid;
    logic                 r_out_valid;
    logic                 r_skid_valid;

    logic       accept;
    logic       pop;
    logic [1:0] sel;
    logic [7:0] diffs;
    logic       pulse;
    logic [2:0] irq_en;

    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_irq       = r_out.irq;
    assign o_expired   = r_out.expired;

    for (genvar g = 0; g < tctmr_pkg::NUM_CNT; g++) begin : g_cnt
        tctmr_counter u_counter (
            .i_count (r_count[g]),
            .i_latch (r_latch[g]),
            .i_dual  (r_ctrl[g][tctmr_pkg::CTRL_DUAL]),
            .o_step  (cnt_step[g])
        );
    end

    always_comb begin
        n_ctrl      = r_ctrl;
        n_latch     = r_latch;
        n_count     = r_count;
        n_running   = r_running;
        n_timeout   = r_timeout;
        n_seen      = r_seen;
        n_hbuf      = r_hbuf;
        n_lbuf      = r_lbuf;
        res         = '0;
        sel         = i_address[2:1] - 2'd1;
        diffs       = '0;
        pulse       = 1'b0;
        irq_en      = '0;
        unique case (i_operation)
            tctmr_pkg::OP_READ: begin
                if (i_address == tctmr_pkg::ADDR_CTRL_A) begin
                    res.read_data = 8'd0;
                end else if (i_address == tctmr_pkg::ADDR_CTRL_B) begin
                    for (int i = 0; i < tctmr_pkg::NUM_CNT; i++) begin
                        irq_en[i] = r_ctrl[i][tctmr_pkg::CTRL_IRQEN];
                    end
                    res.read_data = {|(r_timeout & irq_en), 4'd0, r_timeout};
                    n_seen        = r_seen | r_timeout;
                end else if (!i_address[0]) begin
                    if (r_seen[sel]) begin
                        n_timeout[sel] = 1'b0;
                    end
                    n_lbuf        = r_count[sel][7:0];
                    res.read_data = r_count[sel][15:8];
                end else begin
                    res.read_data = r_lbuf;
                end
            end
            tctmr_pkg::OP_WRITE: begin
                if (i_address == tctmr_pkg::ADDR_CTRL_A ||
                    i_address == tctmr_pkg::ADDR_CTRL_B) begin
                    if (i_address == tctmr_pkg::ADDR_CTRL_B) begin
                        sel = 2'd1;
                    end else if (r_ctrl[1][tctmr_pkg::CTRL_HOLD]) begin
                        sel = 2'd0;
                    end else begin
                        sel = 2'd2;
                    end
                    diffs        = i_write_data ^ r_ctrl[sel];
                    n_ctrl[sel]  = i_write_data;
                    if (sel == 2'd0 && diffs[tctmr_pkg::CTRL_HOLD]) begin
                        if (i_write_data[tctmr_pkg::CTRL_HOLD]) begin
                            n_running = '0;
                        end else begin
                            n_running = '1;
                            n_count   = r_latch;
                        end
                        n_timeout = '0;
                    end
                    if (diffs[tctmr_pkg::CTRL_INTCLK]) begin
                        n_count[sel]   = r_latch[sel];
                        n_running[sel] = 1'b1;
                    end
                end else if (!i_address[0]) begin
                    n_hbuf = i_write_data;
                end else begin
                    n_latch[sel]   = {r_hbuf, i_write_data};
                    n_timeout[sel] = 1'b0;
                    if (!r_ctrl[sel][tctmr_pkg::CTRL_NORELOAD]) begin
                        n_count[sel]   = {r_hbuf, i_write_data};
                        n_running[sel] = 1'b1;
                    end
                end
            end
            tctmr_pkg::OP_TICK: begin
                if (!r_ctrl[0][tctmr_pkg::CTRL_HOLD]) begin
                    for (int i = 0; i < tctmr_pkg::NUM_CNT; i++) begin
                        pulse = r_ctrl[i][tctmr_pkg::CTRL_INTCLK] ? i_internal_clock
                                                                  : i_external_clocks[i];
                        if (r_running[i] && pulse) begin
                            n_count[i] = cnt_step[i].count;
                            if (cnt_step[i].fired) begin
                                n_timeout[i]   = 1'b1;
                                n_seen[i]      = 1'b0;
                                res.expired[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < tctmr_pkg::NUM_CNT; i++) begin
            irq_en[i] = n_ctrl[i][tctmr_pkg::CTRL_IRQEN];
        end
        res.irq = |(n_timeout & irq_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tctmr_pkg::NUM_CNT; i++) begin
                r_ctrl[i]  <= '0;
                r_latch[i] <= tctmr_pkg::COUNT_RESET;
                r_count[i] <= tctmr_pkg::COUNT_RESET;
            end
            r_running    <= '0;
            r_timeout    <= '0;
            r_seen       <= '0;
            r_hbuf       <= '0;
            r_lbuf       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_ctrl    <= n_ctrl;
                r_latch   <= n_latch;
                r_count   <= n_count;
                r_running <= n_running;
                r_timeout <= n_timeout;
                r_seen    <= n_seen;
                r_hbuf    <= n_hbuf;
                r_lbuf    <= n_lbuf;
            end
            if (pop) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= r_out_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

endmodule

### rtl/core/tctmr_counter.sv
// One clock pulse of a single down-counter in word or dual-byte mode.
module tctmr_counter (
    input  logic [15:0]          i_count,
    input  logic [15:0]          i_latch,
    input  logic                 i_dual,
    output tctmr_pkg::t_cnt_step o_step
);

    logic [7:0] lo;
    logic [7:0] hi;

    always_comb begin
        lo           = i_count[7:0];
        hi           = i_count[15:8];
        o_step.fired = 1'b0;
        if (i_dual) begin
            if (lo != 8'd0) begin
                lo = lo - 8'd1;
            end else begin
                lo = i_latch[7:0];
                if (hi == 8'd0) begin
                    hi           = i_latch[15:8];
                    o_step.fired = 1'b1;
                end else begin
                    hi = hi - 8'd1;
                end
            end
            o_step.count = {hi, lo};
        end else begin
            if (i_count == 16'd0) begin
                o_step.count = i_latch;
                o_step.fired = 1'b1;
            end else begin
                o_step.count = i_count - 16'd1;
            end
        end
    end

endmodule

### rtl/core/tctmr_checker.sv
// Port-level checker for the three-channel timer, bound to the top level.
`include "three_channel_programmable_timer_unit_macros.svh"

module tctmr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_data,
    input logic       o_irq,
    input logic [2:0] o_expired
);

    `TCTMR_ASSERT_RST(a_reset_empty, !i_rst_n, !o_out_valid && o_in_ready, "not empty after reset")
    `TCTMR_ASSERT_NXT(a_result_held, o_out_valid && !i_out_ready, o_out_valid && $stable(o_read_data) && $stable(o_irq) && $stable(o_expired), "stalled result changed")
    `TCTMR_ASSERT_NXT(a_result_follows, i_in_valid && o_in_ready && !o_out_valid, o_out_valid, "accepted request gave no result")
    `TCTMR_ASSERT_IMP(a_skid_order, !o_in_ready, o_out_valid, "skid full with output empty")
    `TCTMR_ASSERT_IMP(a_expiry_no_data, o_out_valid && o_expired != 3'd0, o_read_data == 8'd0, "expiry on a read")

endmodule

bind three_channel_programmable_timer_unit tctmr_checker u_tctmr_checker (.*);

### bench/three_channel_programmable_timer_unit_tb.sv
// Self-checking testbench for the three-channel programmable timer unit.
module three_channel_programmable_timer_unit_tb;

    localparam logic [1:0] OP_SPARE       = 2'd3;
    localparam int         RANDOM_ITEMS   = 450;
    localparam int         WATCHDOG_LIMIT = 400;

    typedef struct {
        logic [1:0] op;
        logic [2:0] addr;
        logic [7:0] data;
        logic [2:0] ext;
        logic       intclk;
        bit         settle;
    } t_timer_req;

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_in_valid        = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_operation       = '0;
    logic [2:0] i_address         = '0;
    logic [7:0] i_write_data      = '0;
    logic [2:0] i_external_clocks = '0;
    logic       i_internal_clock  = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready       = 1'b0;
    logic [7:0] o_read_data;
    logic       o_irq;
    logic [2:0] o_expired;

    three_channel_programmable_timer_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_external_clocks (i_external_clocks),
        .i_internal_clock  (i_internal_clock),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_read_data       (o_read_data),
        .o_irq             (o_irq),
        .o_expired         (o_expired)
    );

    always #5 i_clk = ~i_clk;

    // timer state as predicted
    logic [7:0]  timer_ctrl  [tctmr_pkg::NUM_CNT] = '{default: 8'h00};
    logic [15:0] timer_latch [tctmr_pkg::NUM_CNT] = '{default: tctmr_pkg::COUNT_RESET};
    logic [15:0] timer_count [tctmr_pkg::NUM_CNT] = '{default: tctmr_pkg::COUNT_RESET};
    logic [2:0]  run_mask     = '0;
    logic [2:0]  timeout_mask = '0;
    logic [2:0]  seen_mask    = '0;
    logic [7:0]  msb_buf      = '0;
    logic [7:0]  lsb_buf      = '0;

    t_timer_req           req_queue [$];
    tctmr_pkg::t_result   awaited_results [$];
    bit                   drain_before_next = 1'b0;
    int                   error_count = 0;

    logic                 in_taken   = 1'b0;
    logic                 out_taken  = 1'b0;
    int unsigned          send_gap   = 0;
    bit                   send_burst = 1'b0;
    int unsigned          recv_stall = 0;
    bit                   recv_burst = 1'b0;
    int unsigned          idle_cycles = 0;
    t_timer_req           nxt;
    tctmr_pkg::t_result   want;

    function automatic logic irq_pending();
        logic f;
        f = 1'b0;
        for (int i = 0; i < tctmr_pkg::NUM_CNT; i++)
            if (timeout_mask[i] && timer_ctrl[i][tctmr_pkg::CTRL_IRQEN])
                f = 1'b1;
        return f;
    endfunction

    function automatic void reload_counter(int c);
        timer_count[c] = timer_latch[c];
        run_mask[c]    = 1'b1;
    endfunction

    function automatic logic clock_counter(int c);
        logic [7:0] lo;
        logic [7:0] hi;
        logic       fired;
        fired = 1'b0;
        if (timer_ctrl[c][tctmr_pkg::CTRL_DUAL]) begin
            lo = timer_count[c][7:0];
            hi = timer_count[c][15:8];
            if (lo != 0) begin
                lo = lo - 1;
            end else begin
                lo = timer_latch[c][7:0];
                if (hi == 0) begin
                    hi    = timer_latch[c][15:8];
                    fired = 1'b1;
                end else begin
                    hi = hi - 1;
                end
            end
            timer_count[c] = {hi, lo};
        end else if (timer_count[c] == 0) begin
            timer_count[c] = timer_latch[c];
            fired          = 1'b1;
        end else begin
            timer_count[c] = timer_count[c] - 1;
        end
        if (fired) begin
            timeout_mask[c] = 1'b1;
            seen_mask[c]    = 1'b0;
        end
        return fired;
    endfunction

    function automatic void bus_write(logic [2:0] addr, logic [7:0] data);
        int         c;
        logic [7:0] diffs;
        if (addr == tctmr_pkg::ADDR_CTRL_A || addr == tctmr_pkg::ADDR_CTRL_B) begin
            c = (addr == tctmr_pkg::ADDR_CTRL_B) ? 1
                : (timer_ctrl[1][tctmr_pkg::CTRL_HOLD] ? 0 : 2);
            diffs = data ^ timer_ctrl[c];
            timer_ctrl[c] = data;
            if (c == 0 && diffs[tctmr_pkg::CTRL_HOLD]) begin
                if (data[tctmr_pkg::CTRL_HOLD])
                    run_mask = '0;
                else
                    for (int i = 0; i < tctmr_pkg::NUM_CNT; i++)
                        reload_counter(i);
                timeout_mask = '0;
            end
            if (diffs[tctmr_pkg::CTRL_INTCLK])
                reload_counter(c);
        end else if (!addr[0]) begin
            msb_buf = data;
        end else begin
            c = int'(addr[2:1]) - 1;
            timer_latch[c]  = {msb_buf, data};
            timeout_mask[c] = 1'b0;
            if (!timer_ctrl[c][tctmr_pkg::CTRL_NORELOAD])
                reload_counter(c);
        end
    endfunction

    function automatic logic [7:0] bus_read(logic [2:0] addr);
        int         c;
        logic [7:0] s;
        if (addr == tctmr_pkg::ADDR_CTRL_A)
            return 8'h00;
        if (addr == tctmr_pkg::ADDR_CTRL_B) begin
            s = {5'b0, timeout_mask};
            s[tctmr_pkg::STAT_IRQ] = irq_pending();
            seen_mask = seen_mask | timeout_mask;
            return s;
        end
        if (!addr[0]) begin
            c = int'(addr[2:1]) - 1;
            if (seen_mask[c])
                timeout_mask[c] = 1'b0;
            lsb_buf = timer_count[c][7:0];
            return timer_count[c][15:8];
        end
        return lsb_buf;
    endfunction

    function automatic tctmr_pkg::t_result step_timer(logic [1:0] op, logic [2:0] addr,
                                                      logic [7:0] data, logic [2:0] ext,
                                                      logic intclk);
        tctmr_pkg::t_result r;
        logic               pulse;
        r = '0;
        case (op)
            tctmr_pkg::OP_READ:  r.read_data = bus_read(addr);
            tctmr_pkg::OP_WRITE: bus_write(addr, data);
            tctmr_pkg::OP_TICK: begin
                if (!timer_ctrl[0][tctmr_pkg::CTRL_HOLD]) begin
                    for (int c = 0; c < tctmr_pkg::NUM_CNT; c++) begin
                        if (run_mask[c]) begin
                            pulse = timer_ctrl[c][tctmr_pkg::CTRL_INTCLK] ? intclk
                                                                          : ext[c];
                            if (pulse && clock_counter(c))
                                r.expired[c] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.irq = irq_pending();
        return r;
    endfunction

    task automatic push_req(input logic [1:0] op, input logic [2:0] addr,
                            input logic [7:0] data, input logic [2:0] ext,
                            input logic intclk);
        t_timer_req r;
        r.op     = op;
        r.addr   = addr;
        r.data   = data;
        r.ext    = ext;
        r.intclk = intclk;
        r.settle = drain_before_next;
        drain_before_next = 1'b0;
        req_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        $display("mismatch at %0t on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
        error_count++;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (req_queue.size() != 0
                         && !(req_queue[0].settle && awaited_results.size() != 0)) begin
                nxt = req_queue.pop_front();
                i_operation       <= nxt.op;
                i_address         <= nxt.addr;
                i_write_data      <= nxt.data;
                i_external_clocks <= nxt.ext;
                i_internal_clock  <= nxt.intclk;
                i_in_valid        <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 3);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
                i_out_ready <= (recv_stall == 0);
                if (recv_stall != 0)
                    recv_stall = recv_stall - 1;
            end else if (recv_stall != 0) begin
                i_out_ready <= 1'b0;
                recv_stall = recv_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor: check results, predict accepted requests, watchdog
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_in_valid && o_in_ready;
        out_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", o_read_data, 8'h00);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_read_data !== want.read_data)
                        report_mismatch("read_data", o_read_data, want.read_data);
                    if (o_irq !== want.irq)
                        report_mismatch("irq", {7'b0, o_irq}, {7'b0, want.irq});
                    if (o_expired !== want.expired)
                        report_mismatch("expired", {5'b0, o_expired}, {5'b0, want.expired});
                end
            end
            if (i_in_valid && o_in_ready)
                awaited_results.push_back(step_timer(i_operation, i_address, i_write_data,
                                                     i_external_clocks, i_internal_clock));
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("three_channel_programmable_timer_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned kind;
        int unsigned n;
        int unsigned c;
        int unsigned directed_count;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  d;
        logic [2:0]  a;

        // reset values, then hold and hold-release
        push_req(tctmr_pkg::OP_READ, tctmr_pkg::ADDR_CTRL_B, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_READ, tctmr_pkg::ADDR_CTRL_A, 8'hff, 3'b111, 1'b1);
        push_req(tctmr_pkg::OP_READ, 3'd2, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_READ, 3'd3, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, tctmr_pkg::ADDR_CTRL_B, 8'h01, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, tctmr_pkg::ADDR_CTRL_A, 8'h01, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, 3'd2, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, 3'd3, 8'h02, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_TICK, 3'd0, 8'h00, 3'b111, 1'b1);
        push_req(tctmr_pkg::OP_WRITE, tctmr_pkg::ADDR_CTRL_A, 8'h42, 3'b000, 1'b0);
        repeat (3) push_req(tctmr_pkg::OP_TICK, 3'd0, 8'h00, 3'b000, 1'b1);
        // status marks seen, count read then clears the flag
        push_req(tctmr_pkg::OP_READ, tctmr_pkg::ADDR_CTRL_B, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_READ, 3'd2, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_READ, 3'd3, 8'h00, 3'b000, 1'b0);
        // counter 1 dual-byte, internal clock, no reload on latch write
        push_req(tctmr_pkg::OP_WRITE, tctmr_pkg::ADDR_CTRL_B, 8'h56, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, 3'd4, 8'h01, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, 3'd5, 8'h01, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, tctmr_pkg::ADDR_CTRL_A, 8'hff, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, 3'd6, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_WRITE, 3'd7, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_TICK, 3'd7, 8'hff, 3'b111, 1'b1);
        push_req(OP_SPARE, 3'd5, 8'haa, 3'b101, 1'b1);
        push_req(tctmr_pkg::OP_WRITE, tctmr_pkg::ADDR_CTRL_A, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_TICK, 3'd0, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_READ, 3'd6, 8'h00, 3'b000, 1'b0);
        push_req(tctmr_pkg::OP_READ, 3'd7, 8'h00, 3'b000, 1'b0);
        directed_count = req_queue.size();

        drain_before_next = 1'b1;
        while (req_queue.size() < directed_count + RANDOM_ITEMS) begin
            if ($urandom_range(0, 59) == 0)
                drain_before_next = 1'b1;
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    c = $urandom_range(0, 2);
                    n = $urandom_range(0, 5);
                    hi = (n == 0) ? 8'($urandom) : (n < 3) ? 8'($urandom_range(1, 2)) : 8'h00;
                    lo = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 6));
                    push_req(tctmr_pkg::OP_WRITE, 3'(2 * c + 2), hi,
                             3'($urandom), 1'($urandom));
                    push_req(tctmr_pkg::OP_WRITE, 3'(2 * c + 3), lo,
                             3'($urandom), 1'($urandom));
                end
                2: begin
                    a = 3'($urandom_range(0, 1));
                    d = 8'($urandom);
                    if (a == tctmr_pkg::ADDR_CTRL_A && $urandom_range(0, 3) != 0)
                        d[tctmr_pkg::CTRL_HOLD] = 1'b0;
                    push_req(tctmr_pkg::OP_WRITE, a, d, 3'($urandom), 1'($urandom));
                end
                3, 4, 5, 6: begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                        push_req(tctmr_pkg::OP_TICK, 3'($urandom), 8'($urandom),
                                 3'($urandom), $urandom_range(0, 3) != 0);
                end
                7: begin
                    c = $urandom_range(0, 2);
                    push_req(tctmr_pkg::OP_READ, tctmr_pkg::ADDR_CTRL_B, 8'($urandom),
                             3'($urandom), 1'($urandom));
                    push_req(tctmr_pkg::OP_READ, 3'(2 * c + 2), 8'($urandom),
                             3'($urandom), 1'($urandom));
                    push_req(tctmr_pkg::OP_READ, 3'(2 * c + 3), 8'($urandom),
                             3'($urandom), 1'($urandom));
                end
                8: push_req(tctmr_pkg::OP_READ, 3'($urandom), 8'($urandom),
                            3'($urandom), 1'($urandom));
                default: push_req(2'($urandom), 3'($urandom), 8'($urandom), 3'($urandom),
                                  1'($urandom));
            endcase
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (req_queue.size() != 0 || i_in_valid || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (error_count == 0)
            $display("three_channel_programmable_timer_unit verification clean");
        else
            $display("three_channel_programmable_timer_unit verification failed");
        $finish;
    end

endmodule
